### rtl/ttag_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, register indexes and control types of the address generator.
package ttag_pkg;

    localparam int MAX_RANK_DEF  = 6;
    localparam int DIM_BITS_DEF  = 10;
    localparam int ADDR_BITS_DEF = 32;

    localparam int RANK_W   = 3;
    localparam int DIMS_W   = 60;
    localparam int ORDER_W  = 18;
    localparam int AXIS_W   = 3;
    localparam int OFFSET_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [RANK_W-1:0]  RANK_RESET  = 3'd0;
    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 60'd1127000493261825;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 18'd189896;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK  = 2'd0,
        CFG_DIMS  = 2'd1,
        CFG_ORDER = 2'd2
    } cfg_index_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic stride_init;   // preset size 1 / stride 0 before a stride pass
        logic stride_load;   // a stride pass step is on the broadcast bus
        logic start;         // a word was accepted: apply restart and unused clears
        logic restart;       // restart bit of the accepted word
        logic advance;       // step the odometer
    } cell_ctl_t;

endpackage

### rtl/ttag_if.sv
`timescale 1ns / 1ps
// Interfaces: valid/ready channels for restart words and address words.
interface ttag_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface ttag_addr_if;
    logic                          valid;
    logic                          ready;
    logic [ttag_pkg::OFFSET_W-1:0] source_offset;
    logic                          last;

    modport source (output valid, output source_offset, output last, input ready);
    modport sink (input valid, input source_offset, input last, output ready);
endinterface

### rtl/ttag_cell.sv
`timescale 1ns / 1ps
// Cell: one output axis counter with its size, stride, product and partial sum stage.
module ttag_cell #(
    parameter int IDX       = 0,
    parameter int DIM_BITS  = ttag_pkg::DIM_BITS_DEF,
    parameter int ADDR_BITS = ttag_pkg::ADDR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ttag_pkg::cell_ctl_t         ctl,
    input  logic [ttag_pkg::RANK_W-1:0] rank,
    input  logic [ttag_pkg::AXIS_W-1:0] axis,
    input  logic [ttag_pkg::AXIS_W-1:0] step,
    input  logic [ADDR_BITS-1:0]        stride_val,
    input  logic [DIM_BITS-1:0]         dim_val,
    input  logic [ADDR_BITS-1:0]        psum_in,
    output logic [ADDR_BITS-1:0]        psum_out,
    input  logic                        carry_in,
    output logic                        carry_out
);
    import ttag_pkg::*;

    localparam logic [RANK_W-1:0] IDX_L = RANK_W'(IDX);

    logic [DIM_BITS-1:0]           counter_reg, counter_next;
    logic [DIM_BITS-1:0]           size_reg;
    logic [ADDR_BITS-1:0]          stride_reg;
    logic [ADDR_BITS-1:0]          prod_reg;
    logic [ADDR_BITS-1:0]          psum_reg;
    logic [ADDR_BITS+DIM_BITS-1:0] prod_full;
    logic                          active;
    logic                          wrap;

    assign active    = IDX_L < rank;
    assign wrap      = ({1'b0, counter_reg} + 1'b1) >= {1'b0, size_reg};
    assign carry_out = active ? (carry_in & wrap) : carry_in;
    assign prod_full = {{ADDR_BITS{1'b0}}, counter_reg} * {{DIM_BITS{1'b0}}, stride_reg};
    assign psum_out  = psum_reg;

    always_comb
    begin
        counter_next = counter_reg;
        if (ctl.start && (ctl.restart || !active))
        begin
            counter_next = '0;
        end
        else if (ctl.advance && active && carry_in)
        begin
            counter_next = wrap ? '0 : counter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
        end
    end

    // Size and stride of the walked input axis, latched during the stride pass.
    always_ff @(posedge clk)
    begin
        if (ctl.stride_init)
        begin
            size_reg   <= DIM_BITS'(1);
            stride_reg <= '0;
        end
        else if (ctl.stride_load && step == axis && axis < rank)
        begin
            size_reg   <= dim_val;
            stride_reg <= stride_val;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[ADDR_BITS-1:0];
        psum_reg <= psum_in + prod_reg;
    end

endmodule

### rtl/tensor_transpose_address_gen_unit.sv
`timescale 1ns / 1ps
// Top level: permuted-order tensor walk producing row-major source offsets.
//
// Usage
//   cmd  : restart words in; restart = 1 starts the walk over at the first element.
//   addr : one address word out per restart word: source_offset and last,
//          last = 1 on the final element of the walk, after which it wraps to zero.
//   cfg  : write port (cfg_we, cfg_index, cfg_wdata) for rank, packed axis sizes
//          and packed axis order. Write only while no word is in flight.
// Timing
//   A row of MAX_RANK cells holds the axis counters; each cell multiplies its
//   counter by its stride and adds the product to the partial sum handed down
//   the chain, one cell per cycle. A new word is taken only after the word before
//   it has been captured into the output register: the chain depth sets the
//   wait between acceptance and capture.
//   After reset and after every configuration write a stride pass runs through
//   one shared multiplier; cmd.ready stays low meanwhile.
// Reset and stalls
//   Reset loads the default configuration, clears all counters and starts a
//   stride pass. A stalled addr word holds in the output register; the next
//   cmd word may still be accepted and summed, and its result waits until the
//   output register frees up.
module tensor_transpose_address_gen_unit #(
    parameter int MAX_RANK  = ttag_pkg::MAX_RANK_DEF,
    parameter int DIM_BITS  = ttag_pkg::DIM_BITS_DEF,
    parameter int ADDR_BITS = ttag_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ttag_cmd_if.sink                       cmd,
    ttag_addr_if.source                    addr,
    input  logic                           cfg_we,
    input  logic [ttag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttag_pkg::DIMS_W-1:0]    cfg_wdata
);
    import ttag_pkg::*;

    localparam int WAIT_CYC = MAX_RANK + 1;
    localparam int WAIT_W   = $clog2(WAIT_CYC + 1);
    localparam logic [RANK_W-1:0] MAX_RANK_L = RANK_W'(MAX_RANK);
    localparam logic [AXIS_W-1:0] LAST_STEP  = AXIS_W'(MAX_RANK - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SUM
    } state_t;

    // Configuration registers
    logic [RANK_W-1:0]  rank_reg;
    logic [DIMS_W-1:0]  dims_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [RANK_W-1:0]  eff_rank;

    // Stride pass
    logic                          init_reg;
    logic                          busy_reg;
    logic [AXIS_W-1:0]             step_reg;
    logic [ADDR_BITS-1:0]          stride_reg;
    logic [DIM_BITS-1:0]           step_dim;
    logic [ADDR_BITS+DIM_BITS-1:0] stride_full;

    // Word sequencing and output register
    state_t               state_reg;
    logic [WAIT_W-1:0]    wait_reg;
    logic                 out_valid_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic                 out_last_reg;
    logic                 accept;
    logic                 capture;
    logic [OFFSET_W-1:0]  sum_word;

    // Cell chain
    cell_ctl_t            ctl;
    logic [ADDR_BITS-1:0] psum [MAX_RANK];
    logic                 carry [MAX_RANK+1];

    assign eff_rank = (rank_reg > MAX_RANK_L) ? MAX_RANK_L : rank_reg;

    // Configuration writes; any write reruns the stride pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= RANK_RESET;
            dims_reg  <= DIMS_RESET;
            order_reg <= ORDER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RANK:  rank_reg  <= cfg_wdata[RANK_W-1:0];
                CFG_DIMS:  dims_reg  <= cfg_wdata;
                CFG_ORDER: order_reg <= cfg_wdata[ORDER_W-1:0];
                default:   ;
            endcase
        end
    end

    // Size of the input axis the stride pass is on; a size of zero counts as one.
    always_comb
    begin
        step_dim = DIM_BITS'(1);
        for (int a = 0; a < MAX_RANK; a++)
        begin
            if (step_reg == AXIS_W'(a) && dims_reg[DIM_BITS*a +: DIM_BITS] != '0)
            begin
                step_dim = dims_reg[DIM_BITS*a +: DIM_BITS];
            end
        end
    end

    assign stride_full = {{DIM_BITS{1'b0}}, stride_reg} * {{ADDR_BITS{1'b0}}, step_dim};

    // Stride pass: walk input axes innermost first, carrying the running product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
            busy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            init_reg <= 1'b1;
            busy_reg <= 1'b0;
        end
        else if (init_reg)
        begin
            init_reg <= 1'b0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg && step_reg == '0)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_reg)
        begin
            step_reg   <= LAST_STEP;
            stride_reg <= ADDR_BITS'(1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg < eff_rank)
            begin
                stride_reg <= stride_full[ADDR_BITS-1:0];
            end
        end
    end

    // Handshake and sequencing
    assign cmd.ready = (state_reg == ST_IDLE) && !init_reg && !busy_reg && !cfg_we;
    assign accept    = cmd.valid && cmd.ready;
    assign capture   = (state_reg == ST_SUM) && (wait_reg == '0)
                       && (!out_valid_reg || addr.ready);

    assign ctl.stride_init = init_reg;
    assign ctl.stride_load = busy_reg && !init_reg;
    assign ctl.start       = accept;
    assign ctl.restart     = cmd.restart;
    assign ctl.advance     = capture;

    // Chain: partial sums flow from cell 0 upward, the odometer carry from the
    // innermost cell downward.
    assign carry[MAX_RANK] = 1'b1;

    for (genvar i = 0; i < MAX_RANK; i++)
    begin : g_cell
        logic [ADDR_BITS-1:0] psum_prev;
        if (i == 0)
        begin : g_first
            assign psum_prev = '0;
        end
        else
        begin : g_next
            assign psum_prev = psum[i-1];
        end

        ttag_cell #(
            .IDX       (i),
            .DIM_BITS  (DIM_BITS),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .rank       (eff_rank),
            .axis       (order_reg[AXIS_W*i +: AXIS_W]),
            .step       (step_reg),
            .stride_val (stride_reg),
            .dim_val    (step_dim),
            .psum_in    (psum_prev),
            .psum_out   (psum[i]),
            .carry_in   (carry[i+1]),
            .carry_out  (carry[i])
        );
    end

    // Fit the finished sum to the output width.
    if (ADDR_BITS >= OFFSET_W)
    begin : g_trunc
        assign sum_word = psum[MAX_RANK-1][OFFSET_W-1:0];
    end
    else
    begin : g_extend
        assign sum_word = {{(OFFSET_W-ADDR_BITS){1'b0}}, psum[MAX_RANK-1]};
    end

    // State and output register: wait for the sum to leave the last cell, then
    // capture it and step the odometer in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SUM;
                        wait_reg  <= WAIT_W'(WAIT_CYC);
                    end
                end
                ST_SUM:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_reg <= wait_reg - 1'b1;
                    end
                    else if (capture)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (addr.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            out_offset_reg <= sum_word;
            out_last_reg   <= carry[0];
        end
    end

    assign addr.valid         = out_valid_reg;
    assign addr.source_offset = out_offset_reg;
    assign addr.last          = out_last_reg;

endmodule
